@@ rtl/cdad_pkg.sv @@
`timescale 1ns / 1ps

package cdad_pkg;

  localparam int YearW     = 14;
  localparam int DayW      = 5;
  localparam int MonthW    = 4;
  localparam int CountW    = 12;
  localparam int SumW      = 13;
  localparam int CycleW    = 9;
  localparam int ModSteps  = 6;
  localparam int StepW     = 3;

  localparam logic [15:0]        MAX_DAYS_TO_ADD = 16'd4095;
  localparam logic [YearW-1:0]   MIN_YEAR_RESET  = 14'd2025;
  localparam logic [YearW-1:0]   YEAR_CYCLE      = 14'd400;
  localparam logic [YearW-1:0]   YEAR_MAX        = 14'd16383;
  localparam logic [CycleW-1:0]  CYCLE_LAST      = 9'd399;
  localparam logic [CycleW-1:0]  CENTURY_1       = 9'd100;
  localparam logic [CycleW-1:0]  CENTURY_2       = 9'd200;
  localparam logic [CycleW-1:0]  CENTURY_3       = 9'd300;
  localparam logic [MonthW-1:0]  MONTH_JAN       = 4'd1;
  localparam logic [MonthW-1:0]  MONTH_FEB       = 4'd2;
  localparam logic [MonthW-1:0]  MONTH_DEC       = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_WALK,
    ST_DONE
  } cdad_state_t;

  // shared subtractor operands and result
  typedef struct packed {
    logic [YearW-1:0] a;
    logic [YearW-1:0] b;
  } cdad_sub_req_t;

  typedef struct packed {
    logic [YearW-1:0] diff;
    logic             ge;
  } cdad_sub_rsp_t;

  // leap year from the year's position inside the 400 year cycle
  function automatic logic leap_of(input logic [CycleW-1:0] r);
    logic leap;
    leap = (r[1:0] == 2'b00) && (r != CENTURY_1) && (r != CENTURY_2) && (r != CENTURY_3);
    return leap;
  endfunction

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] len;
    case (m)
      MONTH_FEB:                           len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:             len = 5'd30;
      default:                             len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/cdad_sub_unit.sv @@
`timescale 1ns / 1ps

module cdad_sub_unit
  import cdad_pkg::*;
(
  input  cdad_sub_req_t req_i,
  output cdad_sub_rsp_t rsp_o
);

  logic [YearW:0] wide;

  // borrow out of the top bit means a < b
  assign wide       = {1'b0, req_i.a} - {1'b0, req_i.b};
  assign rsp_o.diff = wide[YearW-1:0];
  assign rsp_o.ge   = ~wide[YearW];

endmodule

@@ rtl/calendar_date_add_days_unit.sv @@
`timescale 1ns / 1ps
// steps: accept the request, reduce the year modulo 400 by restoring subtraction,
//   check the date, walk month by month, then load the output register
// a new request is taken only in idle, once the last result is loaded for output;
//   the month walk runs through the single shared subtractor
// reset: rst_n synchronous active low, clears control state and loads minimum_year 2025
module calendar_date_add_days_unit
  import cdad_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // configuration write: minimum_year
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [13:0]  cfg_data,
  // input request
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // day_of_month[4:0], month_number[8:5],
                                   // year_number[22:9], days_to_add[34:23], zero pad
  // result
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // result_day[4:0], result_month[8:5],
                                   // result_year[22:9], zero pad
  output logic         out_tuser   // input_valid
);

  cdad_state_t state_r, state_nxt;

  // configuration register
  logic [YearW-1:0]  min_year_r;

  // working registers of the sequencer
  logic [SumW-1:0]   day_r,   day_nxt;     // running day, holds day + added count
  logic [MonthW-1:0] month_r, month_nxt;
  logic [YearW-1:0]  year_r,  year_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [YearW-1:0]  rem_r,   rem_nxt;     // year mod 400 once reduction is done
  logic [StepW-1:0]  step_r,  step_nxt;
  logic              ok_r,    ok_nxt;

  // original date kept for the invalid echo
  logic [DayW-1:0]   in_day_r;
  logic [MonthW-1:0] in_month_r;

  // output register
  logic              out_valid_r;
  logic [DayW-1:0]   out_day_r;
  logic [MonthW-1:0] out_month_r;
  logic [YearW-1:0]  out_year_r;
  logic              out_ok_r;

  cdad_sub_req_t sub_req;
  cdad_sub_rsp_t sub_rsp;

  logic              in_fire;
  logic              out_free;
  logic              leap_now;
  logic [DayW-1:0]   len_now;
  logic              date_ok;
  logic              walk_more;
  logic [CountW-1:0] count_clamped;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;

  // month length of the current month from the 400 year position
  assign leap_now  = leap_of(rem_r[CycleW-1:0]);
  assign len_now   = month_days(month_r, leap_now);

  // calendar check, month range first so the length lookup is meaningful
  assign date_ok = (month_r >= MONTH_JAN) && (month_r <= MONTH_DEC)
                && (day_r != '0) && (year_r >= min_year_r)
                && (day_r <= {{(SumW-DayW){1'b0}}, len_now});

  // still past the end of this month: day - len is nonzero and not negative
  assign walk_more = sub_rsp.ge && (sub_rsp.diff != '0);

  // count limit, a no-op at the default limit
  assign count_clamped = ({4'b0, count_r} > MAX_DAYS_TO_ADD) ? MAX_DAYS_TO_ADD[CountW-1:0]
                                                             : count_r;

  cdad_sub_unit u_sub (
    .req_i (sub_req),
    .rsp_o (sub_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_MOD;
      ST_MOD:   if (step_r == '0) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = date_ok ? ST_WALK : ST_DONE;
      ST_WALK:  if (!walk_more) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and subtractor operands
  always_comb begin
    in_tready = 1'b0;
    sub_req.a = rem_r;
    sub_req.b = YEAR_CYCLE;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_MOD: begin
        // restoring reduction: try 400 shifted by the step count
        sub_req.a = rem_r;
        sub_req.b = YEAR_CYCLE << step_r;
      end
      ST_WALK: begin
        sub_req.a = {{(YearW-SumW){1'b0}}, day_r};
        sub_req.b = {{(YearW-DayW){1'b0}}, len_now};
      end
      default: begin
        sub_req.a = rem_r;
        sub_req.b = YEAR_CYCLE;
      end
    endcase
  end

  // datapath
  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    ok_nxt    = ok_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          day_nxt   = {{(SumW-DayW){1'b0}}, in_tdata[4:0]};
          month_nxt = in_tdata[8:5];
          year_nxt  = in_tdata[22:9];
          count_nxt = in_tdata[34:23];
          rem_nxt   = in_tdata[22:9];
          step_nxt  = StepW'(ModSteps - 1);
        end
      end
      ST_MOD: begin
        if (sub_rsp.ge) rem_nxt = sub_rsp.diff;
        step_nxt = step_r - 1'b1;
      end
      ST_CHECK: begin
        ok_nxt = date_ok;
        if (date_ok) day_nxt = day_r + {1'b0, count_clamped};
      end
      ST_WALK: begin
        if (walk_more) begin
          day_nxt = sub_rsp.diff[SumW-1:0];
          if (month_r == MONTH_DEC) begin
            month_nxt = MONTH_JAN;
            year_nxt  = year_r + 1'b1;
            // keep the cycle position in step, including the 14 bit wrap
            if (year_r == YEAR_MAX || rem_r[CycleW-1:0] == CYCLE_LAST) begin
              rem_nxt = '0;
            end else begin
              rem_nxt = rem_r + 1'b1;
            end
          end else begin
            month_nxt = month_r + 1'b1;
          end
        end
      end
      default: begin
        day_nxt = day_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_year_r  <= MIN_YEAR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) min_year_r <= cfg_data;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    day_r   <= day_nxt;
    month_r <= month_nxt;
    year_r  <= year_nxt;
    count_r <= count_nxt;
    rem_r   <= rem_nxt;
    step_r  <= step_nxt;
    ok_r    <= ok_nxt;
    if (in_fire) begin
      in_day_r   <= in_tdata[4:0];
      in_month_r <= in_tdata[8:5];
    end
    if (state_r == ST_DONE && out_free) begin
      // invalid dates echo the request unchanged
      out_day_r   <= ok_r ? day_r[DayW-1:0] : in_day_r;
      out_month_r <= ok_r ? month_r : in_month_r;
      out_year_r  <= year_r;
      out_ok_r    <= ok_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_year_r, out_month_r, out_day_r};
  assign out_tuser  = out_ok_r;

endmodule
